// ===== src/gdc_pkg.sv =====
package gdc_pkg;

    // field widths
    localparam int unsigned YEAR_W  = 16;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned OP_W    = 2;
    localparam int unsigned ST_W    = 2;
    localparam int unsigned CNT_IN_W = 8;

    localparam int unsigned IN_TDATA_W  = 40;
    localparam int unsigned OUT_TDATA_W = 32;

    localparam int unsigned COUNT_WIDTH_DEF = 8;

    // operation codes
    localparam logic [OP_W-1:0] OP_SET = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD = 2'd1;
    localparam logic [OP_W-1:0] OP_SUB = 2'd2;

    // status codes
    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_INVALID = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE   = 2'd2;

    // date after reset and range limits
    localparam logic [YEAR_W-1:0]  YEAR_RST  = 16'd2024;
    localparam logic [MONTH_W-1:0] MONTH_RST = 4'd1;
    localparam logic [DAY_W-1:0]   DAY_RST   = 5'd1;
    localparam logic [YEAR_W-1:0]  YEAR_MIN  = 16'd1;
    localparam logic [YEAR_W-1:0]  YEAR_MAX  = 16'hFFFF;
    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
    localparam logic [DAY_W-1:0]   DAY_LAST_DEC = 5'd31;

    // divisibility by 25: y * inverse(25) mod 2^16 stays at or below 65535 / 25
    localparam logic [YEAR_W-1:0] INV25     = 16'd23593;
    localparam logic [YEAR_W-1:0] DIV25_MAX = 16'd2621;

    typedef enum logic [0:0] {
        S_IDLE,
        S_RUN
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic capture;
    } t_dp_cmd;

    typedef struct packed {
        logic finished;
    } t_dp_sts;

endpackage

// ===== src/gdc_datapath.sv =====
module gdc_datapath import gdc_pkg::*; #(
    parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_sts             o_sts,
    input  logic [OP_W-1:0]     i_operation,
    input  logic [YEAR_W-1:0]   i_new_year,
    input  logic [MONTH_W-1:0]  i_new_month,
    input  logic [DAY_W-1:0]    i_new_day,
    input  logic [CNT_IN_W-1:0] i_day_count,
    output logic [YEAR_W-1:0]   o_cur_year,
    output logic [MONTH_W-1:0]  o_cur_month,
    output logic [DAY_W-1:0]    o_cur_day,
    output logic [ST_W-1:0]     o_status
);

    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        logic [YEAR_W-1:0] prod;
        logic              div25;
        prod  = y * INV25;
        div25 = (prod <= DIV25_MAX);
        return (y[1:0] == 2'd0) && ((y[3:0] == 4'd0) || !div25);
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic leap,
                                                    input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        case (m)
            4'd2:                      len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

    logic [YEAR_W-1:0]      r_year,   n_year;
    logic [MONTH_W-1:0]     r_month,  n_month;
    logic [DAY_W-1:0]       r_day,    n_day;
    logic [ST_W-1:0]        r_status, n_status;
    logic [OP_W-1:0]        r_op,     n_op;
    logic [COUNT_WIDTH-1:0] r_count,  n_count;

    logic [YEAR_W-1:0]  r_out_year;
    logic [MONTH_W-1:0] r_out_month;
    logic [DAY_W-1:0]   r_out_day;
    logic [ST_W-1:0]    r_out_status;

    logic [YEAR_W-1:0]  lp_year;
    logic [MONTH_W-1:0] len_month;
    logic               leap;
    logic [DAY_W-1:0]   mon_len;
    logic               set_ok;

    always_comb begin
        // one leap unit shared by set validation and stepping
        lp_year = i_cmd.load ? i_new_year : r_year;
        if (i_cmd.load) begin
            len_month = i_new_month;
        end else if (r_op == OP_SUB) begin
            len_month = r_month - 4'd1;
        end else begin
            len_month = r_month;
        end
        leap    = is_leap(lp_year);
        mon_len = month_len(leap, len_month);
        set_ok  = (i_new_year != '0) && (i_new_month >= MONTH_JAN) &&
                  (i_new_month <= MONTH_DEC) && (i_new_day != '0) &&
                  (i_new_day <= mon_len);

        n_year   = r_year;
        n_month  = r_month;
        n_day    = r_day;
        n_status = r_status;
        n_op     = r_op;
        n_count  = r_count;

        if (i_cmd.load) begin
            n_op     = i_operation;
            n_status = ST_OK;
            n_count  = '0;
            case (i_operation)
                OP_SET: begin
                    if (set_ok) begin
                        n_year  = i_new_year;
                        n_month = i_new_month;
                        n_day   = i_new_day;
                    end else begin
                        n_status = ST_INVALID;
                    end
                end
                OP_ADD, OP_SUB: begin
                    n_count = COUNT_WIDTH'(i_day_count);
                end
                default: begin
                end
            endcase
        end else if (i_cmd.step) begin
            n_count = r_count - 1'b1;
            case (r_op)
                OP_ADD: begin
                    if (r_day < mon_len) begin
                        n_day = r_day + 5'd1;
                    end else if (r_month < MONTH_DEC) begin
                        n_month = r_month + 4'd1;
                        n_day   = DAY_RST;
                    end else if (r_year == YEAR_MAX) begin
                        n_count  = '0;
                        n_status = ST_RANGE;
                    end else begin
                        n_year  = r_year + 16'd1;
                        n_month = MONTH_JAN;
                        n_day   = DAY_RST;
                    end
                end
                OP_SUB: begin
                    if (r_day > 5'd1) begin
                        n_day = r_day - 5'd1;
                    end else if (r_month > MONTH_JAN) begin
                        n_month = r_month - 4'd1;
                        n_day   = mon_len;
                    end else if (r_year == YEAR_MIN) begin
                        n_count  = '0;
                        n_status = ST_RANGE;
                    end else begin
                        n_year  = r_year - 16'd1;
                        n_month = MONTH_DEC;
                        n_day   = DAY_LAST_DEC;
                    end
                end
                default: begin
                    n_count = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_year   <= YEAR_RST;
            r_month  <= MONTH_RST;
            r_day    <= DAY_RST;
            r_status <= ST_OK;
            r_op     <= OP_SET;
            r_count  <= '0;
        end else begin
            r_year   <= n_year;
            r_month  <= n_month;
            r_day    <= n_day;
            r_status <= n_status;
            r_op     <= n_op;
            r_count  <= n_count;
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_out_year   <= r_year;
            r_out_month  <= r_month;
            r_out_day    <= r_day;
            r_out_status <= r_status;
        end
    end

    assign o_sts.finished = (r_count == '0);
    assign o_cur_year     = r_out_year;
    assign o_cur_month    = r_out_month;
    assign o_cur_day      = r_out_day;
    assign o_status       = r_out_status;

endmodule

// ===== src/gdc_ctrl.sv =====
module gdc_ctrl import gdc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    output logic    o_s_tready,
    output logic    o_m_tvalid,
    input  logic    i_m_tready,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_s_tready  = 1'b0;
        o_cmd       = '0;
        out_free    = !r_out_valid || i_m_tready;
        n_out_valid = r_out_valid && !i_m_tready;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RUN;
                end
            end
            S_RUN: begin
                if (!i_sts.finished) begin
                    o_cmd.step = 1'b1;
                end else if (out_free) begin
                    // result word goes to the output register
                    o_cmd.capture = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_m_tvalid = r_out_valid;

    a_load_to_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (r_state == S_RUN))
        else $error("accepted word did not start a run");

    a_step_unfinished: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.step |-> !i_sts.finished)
        else $error("step issued with no days left");

    a_idle_finished: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> i_sts.finished)
        else $error("ready while days still pending");

    a_capture_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> o_m_tvalid)
        else $error("captured result not presented");

endmodule

// ===== src/gregorian_date_counter.sv =====
// gregorian date counter
// slave channel: s_axis_tuser carries the operation (set date, add days,
// subtract days); s_axis_tdata carries year, month, day and the day count.
// master channel: one word per accepted word, with the current date in
// m_axis_tdata and the status (ok, invalid date, year range) in m_axis_tuser.
// a word is accepted in the idle cycle; the date then moves one day per
// cycle on the shared day stepper until the day count runs out, and then
// the result word is loaded into the output register once it is free; a
// set or a zero count goes to the result word with no steps.
// the block works on one word at a time and takes the next word in the
// cycle after the result is loaded into the output register.
// reset sets the date to january 1, 2024 and empties the output register.
// if the receiver stalls, the result word holds in the output register; a
// following word is still taken and computed, but its result waits until
// the output register is free.
module gregorian_date_counter import gdc_pkg::*; #(
    parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // new_year[15:0], new_month[19:16], new_day[24:20], day_count[32:25], zero pad
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // operation[1:0]
    input  logic [OP_W-1:0]        s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // cur_year[15:0], cur_month[19:16], cur_day[24:20], zero pad
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // status[1:0]
    output logic [ST_W-1:0]        m_axis_tuser
);

    t_dp_cmd            cmd;
    t_dp_sts            sts;
    logic [YEAR_W-1:0]  cur_year;
    logic [MONTH_W-1:0] cur_month;
    logic [DAY_W-1:0]   cur_day;

    gdc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    gdc_datapath #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_operation (s_axis_tuser),
        .i_new_year  (s_axis_tdata[15:0]),
        .i_new_month (s_axis_tdata[19:16]),
        .i_new_day   (s_axis_tdata[24:20]),
        .i_day_count (s_axis_tdata[32:25]),
        .o_cur_year  (cur_year),
        .o_cur_month (cur_month),
        .o_cur_day   (cur_day),
        .o_status    (m_axis_tuser)
    );

    assign m_axis_tdata = {7'd0, cur_day, cur_month, cur_year};

endmodule
